// ===== hdl/threshold_triggered_window_capture_defines.svh =====
// Assertion macros used by the window capture RTL.
`ifndef THRESHOLD_TRIGGERED_WINDOW_CAPTURE_DEFINES_SVH
`define THRESHOLD_TRIGGERED_WINDOW_CAPTURE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTWC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("window capture: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TTWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("window capture: next-cycle check failed");

`endif

// ===== hdl/ttwc_pkg.sv =====
// Types, constants and register codes of the window capture block.
`default_nettype none

package ttwc_pkg;

  localparam int CHANNELS          = 4;
  localparam int HISTORY_DEPTH_DEF = 32;

  localparam int SAMPLE_W = 24;
  localparam int NOISE_W  = 23;
  localparam int GAIN_W   = 8;
  localparam int THRESH_W = GAIN_W + NOISE_W;
  localparam int NUMBER_W = 32;
  localparam int PRE_W    = 6;
  localparam int POST_W   = 11;
  localparam int POST_MAX = 1024;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POST   = 3'd6;

  // Register values after reset.
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 8'd4;
  localparam logic [NOISE_W-1:0] NOISE_RST = 23'h7FFFFF;
  localparam logic [PRE_W-1:0]   PRE_RST   = 6'd16;
  localparam logic [POST_W-1:0]  POST_RST  = 11'd48;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [CHANNELS-1:0]     sample_vec_t;
  typedef logic [NOISE_W-1:0]         noise_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic [THRESH_W-1:0]        thresh_t;
  typedef logic [NUMBER_W-1:0]        number_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

endpackage

`default_nettype wire

// ===== hdl/ttwc_if.sv =====
// Stream and configuration interfaces of the window capture block.
`default_nettype none

// Input sample stream.
interface ttwc_in_if;
  import ttwc_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_ch0;
  sample_t sample_ch1;
  sample_t sample_ch2;
  sample_t sample_ch3;
  number_t sample_number;

  modport source (output valid, output sample_ch0, output sample_ch1, output sample_ch2,
                  output sample_ch3, output sample_number, input ready);
  modport sink (input valid, input sample_ch0, input sample_ch1, input sample_ch2,
                input sample_ch3, input sample_number, output ready);
endinterface

// Captured window stream.
interface ttwc_out_if;
  import ttwc_pkg::*;
  logic    valid;
  logic    ready;
  sample_t out_ch0;
  sample_t out_ch1;
  sample_t out_ch2;
  sample_t out_ch3;
  number_t window_start_number;
  logic    end_of_window;

  modport source (output valid, output out_ch0, output out_ch1, output out_ch2,
                  output out_ch3, output window_start_number, output end_of_window,
                  input ready);
  modport sink (input valid, input out_ch0, input out_ch1, input out_ch2,
                input out_ch3, input window_start_number, input end_of_window,
                output ready);
endinterface

// Register write channel.
interface ttwc_cfg_if;
  import ttwc_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  reg_index;
  cfg_data_t wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// ===== hdl/ttwc_detect.sv =====
// Per-channel threshold detector: magnitude of a sample against gain times noise.
`default_nettype none

module ttwc_detect (
  input  ttwc_pkg::gain_t   gain,
  input  ttwc_pkg::noise_t  noise,
  input  ttwc_pkg::sample_t sample,
  output logic              hit
);
  import ttwc_pkg::*;

  thresh_t                 thresh;
  logic [SAMPLE_W-1:0]     mag;

  // Threshold is the product of the gain and this channel's noise level.
  assign thresh = THRESH_W'(gain) * THRESH_W'(noise);

  // Absolute value; the most negative sample maps to its true magnitude.
  assign mag = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;

  // Strictly above the threshold or strictly below its negative.
  assign hit = THRESH_W'(mag) > thresh;

endmodule

`default_nettype wire

// ===== hdl/ttwc_cell.sv =====
// One history cell: holds a multi-channel sample and passes it to its neighbor.
`default_nettype none

module ttwc_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  ttwc_pkg::sample_vec_t d,
  output ttwc_pkg::sample_vec_t q
);
  import ttwc_pkg::*;

  sample_vec_t data_r;
  sample_vec_t data_nxt;

  // Take the neighbor's sample whenever the chain moves.
  always_comb begin
    data_nxt = shift_en ? d : data_r;
  end

  // History reads as zero until it has been written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign q = data_r;

endmodule

`default_nettype wire

// ===== hdl/threshold_triggered_window_capture.sv =====
// A request is taken in the idle state and checked in the evaluate state, which loads a
// windowed sample into the output register once that register is free. No new sample is
// taken until the last one is done. A trigger adds the trigger step plus, when pre count
// is nonzero, a rotation of the history ring past the output tap; a stalled output holds
// the sequence in place.
// Reset (rst_n low, synchronous) zeroes the history, the window state and loads defaults.
`default_nettype none
`include "threshold_triggered_window_capture_defines.svh"

module threshold_triggered_window_capture #(
  parameter int HISTORY_DEPTH = ttwc_pkg::HISTORY_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  ttwc_in_if.sink     in_chan,
  ttwc_out_if.source  out_chan,
  ttwc_cfg_if.sink    cfg_chan
);
  import ttwc_pkg::*;

  localparam int CNT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W = PRE_W + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_ROT  = 2'd2;
  localparam logic [1:0] ST_TRIG = 2'd3;

  // Configuration registers.
  gain_t             gain_r;
  noise_t            noise_r [CHANNELS];
  logic [PRE_W-1:0]  pre_r;
  logic [POST_W-1:0] post_r;

  // Control state.
  logic [1:0]        state_r, state_nxt;
  logic              capturing_r, capturing_nxt;
  logic [POST_W-1:0] rem_r, rem_nxt;
  number_t           win_r, win_nxt;
  logic [PRE_W-1:0]  pre_eff_r, pre_eff_nxt;
  logic [CNT_W-1:0]  rot_cnt_r, rot_cnt_nxt;

  // Held input sample.
  sample_vec_t       samp_r;
  number_t           num_r;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  sample_vec_t       out_smp_r;
  logic              out_eow_r;
  number_t           out_start_r;
  logic              out_load;
  sample_vec_t       out_smp_nxt;
  logic              out_eow_nxt;

  logic              in_acc;
  logic              slot_free;
  logic              shift_en;
  logic              rot_sel;
  logic              emit_now;
  logic              last_rot;
  logic              hit;
  logic [CHANNELS-1:0] hit_vec;
  logic [PRE_W-1:0]  pre_sat;
  logic [POST_W-1:0] post_eff;

  sample_vec_t       cell_d [HISTORY_DEPTH];
  sample_vec_t       cell_q [HISTORY_DEPTH];

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign slot_free      = !out_valid_r || out_chan.ready;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RST;
      for (int k = 0; k < CHANNELS; k++) begin
        noise_r[k] <= NOISE_RST;
      end
      pre_r  <= PRE_RST;
      post_r <= POST_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.reg_index)
        REG_GAIN:   gain_r     <= cfg_chan.wr_data[GAIN_W-1:0];
        REG_NOISE0: noise_r[0] <= cfg_chan.wr_data[NOISE_W-1:0];
        REG_NOISE1: noise_r[1] <= cfg_chan.wr_data[NOISE_W-1:0];
        REG_NOISE2: noise_r[2] <= cfg_chan.wr_data[NOISE_W-1:0];
        REG_NOISE3: noise_r[3] <= cfg_chan.wr_data[NOISE_W-1:0];
        REG_PRE:    pre_r      <= cfg_chan.wr_data[PRE_W-1:0];
        REG_POST:   post_r     <= cfg_chan.wr_data[POST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Capture the incoming sample for evaluation.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      samp_r[0] <= in_chan.sample_ch0;
      samp_r[1] <= in_chan.sample_ch1;
      samp_r[2] <= in_chan.sample_ch2;
      samp_r[3] <= in_chan.sample_ch3;
      num_r     <= in_chan.sample_number;
    end
  end

  // Threshold detectors, one per channel.
  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_det
    ttwc_detect u_det (
      .gain   (gain_r),
      .noise  (noise_r[ch]),
      .sample (samp_r[ch]),
      .hit    (hit_vec[ch])
    );
  end
  assign hit = |hit_vec;

  // History ring: cell 0 takes the new sample, or the oldest cell while rotating.
  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_d[i] = rot_sel ? cell_q[HISTORY_DEPTH-1] : samp_r;
    end else begin : g_body
      assign cell_d[i] = cell_q[i-1];
    end
    ttwc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d        (cell_d[i]),
      .q        (cell_q[i])
    );
  end

  // Window limits after saturation.
  assign pre_sat  = (pre_r > PRE_W'(HISTORY_DEPTH)) ? PRE_W'(HISTORY_DEPTH) : pre_r;
  assign post_eff = (post_r == '0) ? POST_W'(1) :
                    (post_r > POST_W'(POST_MAX)) ? POST_W'(POST_MAX) : post_r;

  // The tap holds a wanted pre-trigger sample once the rotation has passed
  // the older entries.
  assign emit_now = (SUM_W'(rot_cnt_r) + SUM_W'(pre_eff_r)) >= SUM_W'(HISTORY_DEPTH);
  assign last_rot = (rot_cnt_r == CNT_W'(HISTORY_DEPTH - 1));

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    capturing_nxt = capturing_r;
    rem_nxt       = rem_r;
    win_nxt       = win_r;
    pre_eff_nxt   = pre_eff_r;
    rot_cnt_nxt   = rot_cnt_r;
    shift_en      = 1'b0;
    rot_sel       = 1'b0;
    out_load      = 1'b0;
    out_smp_nxt   = samp_r;
    out_eow_nxt   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (capturing_r) begin
          // Inside a window: pass the sample on and count it.
          if (slot_free) begin
            out_load    = 1'b1;
            out_eow_nxt = (rem_r == POST_W'(1));
            rem_nxt     = rem_r - 1'b1;
            if (rem_r == POST_W'(1)) begin
              capturing_nxt = 1'b0;
            end
            shift_en  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (hit) begin
          // Trigger: fix the window and start the history readout.
          win_nxt     = num_r - NUMBER_W'(pre_sat);
          pre_eff_nxt = pre_sat;
          rem_nxt     = post_eff - 1'b1;
          rot_cnt_nxt = '0;
          state_nxt   = (pre_sat == '0) ? ST_TRIG : ST_ROT;
        end else begin
          shift_en  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_ROT: begin
        // One ring step per cycle; hold while a wanted sample cannot be sent.
        if (!emit_now || slot_free) begin
          shift_en    = 1'b1;
          rot_sel     = 1'b1;
          rot_cnt_nxt = rot_cnt_r + 1'b1;
          if (emit_now) begin
            out_load    = 1'b1;
            out_smp_nxt = cell_q[HISTORY_DEPTH-1];
          end
          if (last_rot) begin
            state_nxt = ST_TRIG;
          end
        end
      end
      ST_TRIG: begin
        // Send the trigger sample and store it in the history.
        if (slot_free) begin
          out_load      = 1'b1;
          out_eow_nxt   = (rem_r == '0);
          capturing_nxt = (rem_r != '0);
          shift_en      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      capturing_r <= 1'b0;
      rem_r       <= '0;
      win_r       <= '0;
      pre_eff_r   <= '0;
      rot_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      capturing_r <= capturing_nxt;
      rem_r       <= rem_nxt;
      win_r       <= win_nxt;
      pre_eff_r   <= pre_eff_nxt;
      rot_cnt_r   <= rot_cnt_nxt;
    end
  end

  // Output register: refilled whenever it is empty or being taken.
  assign out_valid_nxt = out_load || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_smp_r   <= out_smp_nxt;
      out_eow_r   <= out_eow_nxt;
      out_start_r <= win_r;
    end
  end

  assign out_chan.valid               = out_valid_r;
  assign out_chan.out_ch0             = out_smp_r[0];
  assign out_chan.out_ch1             = out_smp_r[1];
  assign out_chan.out_ch2             = out_smp_r[2];
  assign out_chan.out_ch3             = out_smp_r[3];
  assign out_chan.window_start_number = out_start_r;
  assign out_chan.end_of_window       = out_eow_r;

  // A running window always has samples left to send.
  `TTWC_ASSERT_NOW(a_capture_has_rem, clk, rst_n, capturing_r, rem_r != '0)
  // The rotation counter stays inside the ring.
  `TTWC_ASSERT_NOW(a_rot_in_range, clk, rst_n, state_r == ST_ROT,
                   rot_cnt_r <= CNT_W'(HISTORY_DEPTH - 1))
  // The readout only ever ends in the trigger step.
  `TTWC_ASSERT_NEXT(a_rot_to_trig, clk, rst_n, state_r == ST_ROT,
                    state_r == ST_ROT || state_r == ST_TRIG)
  // The trigger sample always lands in the output register.
  `TTWC_ASSERT_NEXT(a_trig_emits, clk, rst_n, state_r == ST_TRIG && slot_free,
                    state_r == ST_IDLE && out_valid_r)

endmodule

`default_nettype wire

// ===== test/ttwc_window_checker.sv =====
// Scoreboard for the window capture block: predicts every captured window and checks it.
module ttwc_window_checker (
  input  logic clk,
  input  logic rst_n,
  ttwc_in_if   in_mon,
  ttwc_out_if  out_mon,
  ttwc_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending,
  output logic window_open
);
  timeunit 1ns;
  timeprecision 1ps;
  import ttwc_pkg::*;

  localparam int DEPTH      = HISTORY_DEPTH_DEF;
  localparam int REPORT_MAX = 10;

  // One captured sample as the block should send it.
  typedef struct packed {
    sample_vec_t ch;
    number_t     start;
    logic        last;
  } window_beat_t;

  // Register copies, as written through the configuration channel.
  gain_t             gain_r;
  noise_t            noise_r [CHANNELS];
  logic [PRE_W-1:0]  pre_r;
  logic [POST_W-1:0] post_r;

  // Capture state: history ring and the open window.
  sample_vec_t history [DEPTH];
  int          wr_ptr;
  logic        capturing;
  int          remaining;
  number_t     win_start;

  window_beat_t beat_q [$];
  int           mismatches;

  // A sample triggers when any channel leaves the band of plus or minus gain times noise.
  function automatic logic crosses_threshold(sample_vec_t smp);
    longint lvl;
    longint th;
    for (int j = 0; j < CHANNELS; j++) begin
      lvl = longint'(smp[j]);
      th  = longint'(gain_r) * longint'(noise_r[j]);
      if (lvl > th || lvl < -th) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic queue_beat(sample_vec_t smp, logic last);
    window_beat_t b;
    b.ch    = smp;
    b.start = win_start;
    b.last  = last;
    beat_q.push_back(b);
  endtask

  // Work out the beats that one accepted sample request causes.
  task automatic predict_capture(sample_vec_t smp, number_t num);
    int eff_pre;
    int eff_post;
    int idx;
    if (capturing) begin
      if (remaining > 0) remaining--;
      queue_beat(smp, remaining == 0);
      if (remaining == 0) capturing = 1'b0;
    end else if (crosses_threshold(smp)) begin
      // Pre count saturates at the history depth; post count is kept within 1..POST_MAX.
      eff_pre  = (int'(pre_r) > DEPTH) ? DEPTH : int'(pre_r);
      eff_post = (post_r == '0) ? 1 : (int'(post_r) > POST_MAX) ? POST_MAX : int'(post_r);
      win_start = num - number_t'(eff_pre);
      for (int k = 0; k < eff_pre; k++) begin
        idx = (wr_ptr + DEPTH - eff_pre + k) % DEPTH;
        queue_beat(history[idx], 1'b0);
      end
      remaining = eff_post - 1;
      queue_beat(smp, remaining == 0);
      capturing = (remaining != 0);
    end
    // Every sample enters the history, window or not.
    history[wr_ptr] = smp;
    wr_ptr = (wr_ptr + 1) % DEPTH;
  endtask

  task automatic check_beat(window_beat_t got);
    window_beat_t want;
    if (beat_q.size() == 0) begin
      fail_count++;
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("window beat with nothing expected: ch %0d %0d %0d %0d start %08h end %0b",
                 got.ch[0], got.ch[1], got.ch[2], got.ch[3], got.start, got.last);
      return;
    end
    want = beat_q.pop_front();
    if (got.ch !== want.ch || got.start !== want.start || got.last !== want.last) begin
      fail_count++;
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("window beat mismatch: expected ch %0d %0d %0d %0d start %08h end %0b, %s",
                 want.ch[0], want.ch[1], want.ch[2], want.ch[3], want.start, want.last,
                 $sformatf("got ch %0d %0d %0d %0d start %08h end %0b",
                           got.ch[0], got.ch[1], got.ch[2], got.ch[3], got.start, got.last));
    end
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    window_beat_t got;
    sample_vec_t  smp;
    if (!rst_n) begin
      gain_r = GAIN_RST;
      for (int j = 0; j < CHANNELS; j++) noise_r[j] = NOISE_RST;
      pre_r  = PRE_RST;
      post_r = POST_RST;
      for (int i = 0; i < DEPTH; i++) history[i] = '0;
      wr_ptr     = 0;
      capturing  = 1'b0;
      remaining  = 0;
      win_start  = '0;
      fail_count = 0;
      mismatches = 0;
      beat_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.reg_index)
          REG_GAIN:   gain_r     = cfg_mon.wr_data[GAIN_W-1:0];
          REG_NOISE0: noise_r[0] = cfg_mon.wr_data[NOISE_W-1:0];
          REG_NOISE1: noise_r[1] = cfg_mon.wr_data[NOISE_W-1:0];
          REG_NOISE2: noise_r[2] = cfg_mon.wr_data[NOISE_W-1:0];
          REG_NOISE3: noise_r[3] = cfg_mon.wr_data[NOISE_W-1:0];
          REG_PRE:    pre_r      = cfg_mon.wr_data[PRE_W-1:0];
          REG_POST:   post_r     = cfg_mon.wr_data[POST_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        smp[0] = in_mon.sample_ch0;
        smp[1] = in_mon.sample_ch1;
        smp[2] = in_mon.sample_ch2;
        smp[3] = in_mon.sample_ch3;
        predict_capture(smp, in_mon.sample_number);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.ch[0] = out_mon.out_ch0;
        got.ch[1] = out_mon.out_ch1;
        got.ch[2] = out_mon.out_ch2;
        got.ch[3] = out_mon.out_ch3;
        got.start = out_mon.window_start_number;
        got.last  = out_mon.end_of_window;
        check_beat(got);
      end
    end
    pending     = beat_q.size();
    window_open = capturing;
  end

endmodule

// ===== test/threshold_triggered_window_capture_tb.sv =====
// Top of the window capture testbench: clock, reset, stimulus phases and the verdict.
module threshold_triggered_window_capture_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ttwc_pkg::*;

  localparam int DRAIN_CYCLES = HISTORY_DEPTH_DEF + 16;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam longint SMP_MAX  = 64'sd8388607;
  localparam longint SMP_MIN  = -64'sd8388608;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int     in_idle_pct;
  int     out_stall_pct;
  longint cur_th [CHANNELS];
  int     fail_count;
  int     pending_beats;
  logic   window_open;
  int     cycle_count = 0;

  ttwc_in_if  in_chan ();
  ttwc_out_if out_chan ();
  ttwc_cfg_if cfg_chan ();

  threshold_triggered_window_capture u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  ttwc_window_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_mon     (cfg_chan),
    .fail_count  (fail_count),
    .pending     (pending_beats),
    .window_open (window_open)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random, at the rate of the current phase.
  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Hard stop for a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic sample_vec_t mk_sample(sample_t c0, sample_t c1, sample_t c2, sample_t c3);
    sample_vec_t v;
    v[0] = c0;
    v[1] = c1;
    v[2] = c2;
    v[3] = c3;
    return v;
  endfunction

  // A random register value between lo and hi.
  function automatic cfg_data_t rand_cfg(int unsigned lo, int unsigned hi);
    return cfg_data_t'($urandom_range(hi, lo));
  endfunction

  // A value that stays inside the band of plus or minus th.
  function automatic sample_t quiet_value(longint th);
    longint lo;
    longint hi;
    lo = (-th < SMP_MIN) ? SMP_MIN : -th;
    hi = (th > SMP_MAX) ? SMP_MAX : th;
    return sample_t'(lo + longint'($urandom) % (hi - lo + 1));
  endfunction

  // A value outside the band, when the sample range has room for one.
  function automatic sample_t spike_value(longint th);
    if ($urandom_range(1) == 1 && th < SMP_MAX)
      return sample_t'(th + 1 + longint'($urandom) % (SMP_MAX - th));
    if (th < -SMP_MIN)
      return sample_t'(-th - 1 - longint'($urandom) % (-SMP_MIN - th));
    return quiet_value(th);
  endfunction

  function automatic sample_vec_t random_sample();
    sample_vec_t v;
    for (int j = 0; j < CHANNELS; j++) v[j] = sample_t'($urandom);
    return v;
  endfunction

  // Mostly quiet samples; a spike on one channel when asked, and now and then an extreme.
  function automatic sample_vec_t stimulus_sample(logic spike);
    sample_vec_t v;
    int          ch;
    for (int j = 0; j < CHANNELS; j++) v[j] = quiet_value(cur_th[j]);
    if (spike) begin
      ch = $urandom_range(CHANNELS - 1);
      v[ch] = spike_value(cur_th[ch]);
    end
    if ($urandom_range(99) < 5) begin
      ch = $urandom_range(CHANNELS - 1);
      case ($urandom_range(3))
        0: v[ch] = sample_t'(SMP_MAX);
        1: v[ch] = sample_t'(SMP_MIN);
        2: v[ch] = '0;
        default: v[ch] = '1;
      endcase
    end
    return v;
  endfunction

  task automatic set_mode(int mode);
    case (mode)
      1: begin in_idle_pct = 78; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 78; end
      3: begin in_idle_pct = 32; out_stall_pct = 32; end
      default: begin in_idle_pct = 0; out_stall_pct = 0; end
    endcase
  endtask

  // Write all seven registers, one request each; entered and left at a falling edge.
  task automatic load_config(cfg_data_t g, cfg_data_t n0, cfg_data_t n1, cfg_data_t n2,
                             cfg_data_t n3, cfg_data_t pre, cfg_data_t post);
    cfg_idx_t  regs [7];
    cfg_data_t vals [7];
    regs = '{REG_GAIN, REG_NOISE0, REG_NOISE1, REG_NOISE2, REG_NOISE3, REG_PRE, REG_POST};
    vals = '{g, n0, n1, n2, n3, pre, post};
    for (int i = 0; i < 7; i++) begin
      cfg_chan.valid     <= 1'b1;
      cfg_chan.reg_index <= regs[i];
      cfg_chan.wr_data   <= vals[i];
      @(posedge clk);
      while (!cfg_chan.ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_chan.valid <= 1'b0;
    cur_th[0] = longint'(g[GAIN_W-1:0]) * longint'(n0[NOISE_W-1:0]);
    cur_th[1] = longint'(g[GAIN_W-1:0]) * longint'(n1[NOISE_W-1:0]);
    cur_th[2] = longint'(g[GAIN_W-1:0]) * longint'(n2[NOISE_W-1:0]);
    cur_th[3] = longint'(g[GAIN_W-1:0]) * longint'(n3[NOISE_W-1:0]);
  endtask

  // Send one sample request; valid stays high afterwards until the next call or a pause.
  task automatic send_sample(sample_vec_t smp, number_t num);
    while ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.sample_ch0    <= smp[0];
    in_chan.sample_ch1    <= smp[1];
    in_chan.sample_ch2    <= smp[2];
    in_chan.sample_ch3    <= smp[3];
    in_chan.sample_number <= num;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender until every expected beat has come out.
  task automatic wait_for_results();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (pending_beats != 0);
  endtask

  // Quiet point between phases: nothing expected and the pipeline empty.
  task automatic settle();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One configuration followed by random sample requests under one idling mode.
  task automatic run_phase(cfg_data_t g, cfg_data_t n0, cfg_data_t n1, cfg_data_t n2,
                           cfg_data_t n3, cfg_data_t pre, cfg_data_t post,
                           int count, int mode);
    sample_vec_t smp;
    number_t     num;
    load_config(g, n0, n1, n2, n3, pre, post);
    set_mode(mode);
    num = number_t'($urandom);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 3) wait_for_results();
      if (window_open) smp = random_sample();
      else smp = stimulus_sample(i == 0 || $urandom_range(99) < 12);
      send_sample(smp, num);
      num = ($urandom_range(99) < 3) ? number_t'($urandom) : num + 1;
    end
    // Finish any open window so that the next configuration starts armed.
    while (window_open) begin
      send_sample(random_sample(), num);
      num = num + 1;
    end
    settle();
  endtask

  initial begin
    in_chan.valid         = 1'b0;
    in_chan.sample_ch0    = '0;
    in_chan.sample_ch1    = '0;
    in_chan.sample_ch2    = '0;
    in_chan.sample_ch3    = '0;
    in_chan.sample_number = '0;
    cfg_chan.valid        = 1'b0;
    cfg_chan.reg_index    = REG_GAIN;
    cfg_chan.wr_data      = '0;
    out_chan.ready        = 1'b0;
    set_mode(0);
    for (int j = 0; j < CHANNELS; j++)
      cur_th[j] = longint'(GAIN_RST) * longint'(NOISE_RST);

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset thresholds are out of reach: extremes pass without a trigger.
    send_sample(mk_sample(8388607, 8388607, 8388607, 8388607), 32'hFFFF_FFF0);
    send_sample(mk_sample(-8388608, -8388608, -8388608, -8388608), 32'hFFFF_FFF1);
    settle();

    // Band edges, zero noise, full-scale noise, and post count zero acting as one.
    load_config(1, 100, 200, 0, 8388607, 16, 0);
    send_sample(mk_sample(100, 200, 0, 8388607), 32'hFFFF_FFF2);
    send_sample(mk_sample(-100, -200, 0, -8388607), 32'hFFFF_FFF3);
    // Short history: most pre-trigger entries still hold reset zeros.
    send_sample(mk_sample(101, 0, 0, 0), 32'hFFFF_FFF4);
    send_sample(mk_sample(0, -201, 0, 0), 32'hFFFF_FFF5);
    send_sample(mk_sample(0, 0, -1, 0), 32'hFFFF_FFF6);
    send_sample(mk_sample(0, 0, 0, -8388608), 32'hFFFF_FFF7);
    settle();

    // No pre-trigger samples; the window runs across the sample number wrap.
    load_config(1, 100, 200, 0, 8388607, 0, 3);
    send_sample(mk_sample(500, 0, 0, 0), 32'hFFFF_FFFF);
    send_sample(mk_sample(8388607, -8388608, 1, -1), 32'h0000_0000);
    send_sample(mk_sample(-8388608, 8388607, -1, 1), 32'h0000_0001);
    send_sample(mk_sample(5000, 0, 0, 0), 32'h0000_0002);
    send_sample(mk_sample(3, 2, 0, 1), 32'h0000_0003);
    send_sample(mk_sample(-3, -2, 0, -1), 32'h0000_0004);
    settle();

    // Pre count above the history depth, largest gain, threshold products near the top.
    load_config(255, 1, 8388607, 8388607, 8388607, 63, 2);
    send_sample(mk_sample(255, -8388608, 8388607, -8388608), 32'h0000_0064);
    send_sample(mk_sample(256, 0, 0, 0), 32'h0000_0065);
    send_sample(mk_sample(7, 7, 7, 7), 32'h0000_0066);
    send_sample(mk_sample(-256, 0, 0, 0), 32'h0000_0067);
    send_sample(mk_sample(-7, -7, -7, -7), 32'h0000_0068);
    settle();

    // Random phases across the idling modes.
    run_phase(4, rand_cfg(0, 4000), rand_cfg(0, 4000), rand_cfg(0, 4000),
              rand_cfg(0, 4000), 16, 8, 20, 0);
    run_phase(0, rand_cfg(0, 8388607), rand_cfg(0, 8388607), rand_cfg(0, 8388607),
              rand_cfg(0, 8388607), 0, 1, 20, 1);
    run_phase(255, rand_cfg(0, 30000), rand_cfg(0, 30000), rand_cfg(0, 30000),
              rand_cfg(0, 30000), 32, 3, 20, 2);
    run_phase(255, 8388607, 8388607, 8388607, 1, 31, 5, 20, 3);
    run_phase(rand_cfg(1, 255), rand_cfg(0, 8388607), rand_cfg(0, 8388607),
              rand_cfg(0, 8388607), rand_cfg(0, 8388607), rand_cfg(0, 63),
              rand_cfg(1, 12), 20, 0);
    run_phase(1, rand_cfg(0, 3000000), rand_cfg(0, 3000000), rand_cfg(0, 3000000),
              rand_cfg(0, 3000000), 7, 20, 20, 1);
    run_phase(rand_cfg(0, 255), rand_cfg(0, 50000), rand_cfg(0, 50000),
              rand_cfg(0, 50000), rand_cfg(0, 50000), rand_cfg(0, 63),
              rand_cfg(1, 40), 20, 3);
    run_phase(3, rand_cfg(0, 20000), rand_cfg(0, 20000), rand_cfg(0, 20000),
              rand_cfg(0, 20000), 5, 6, 20, 2);

    // Post count above its range: the window stays open past the last request sent here.
    load_config(2, rand_cfg(0, 1000000), rand_cfg(0, 1000000), rand_cfg(0, 1000000),
                rand_cfg(0, 1000000), 63, 2047);
    set_mode(3);
    for (int i = 0; i < 20; i++) begin
      send_sample(stimulus_sample(i == 0), number_t'(32'h0000_1000 + i));
    end
    wait_for_results();

    if (fail_count == 0 && pending_beats == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
